FILE: sv/pill_dispense_controller_core_assert.svh
// Assertion macros shared by the checker files of the dispense controller.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef PILL_DISPENSE_CONTROLLER_CORE_ASSERT_SVH
`define PILL_DISPENSE_CONTROLLER_CORE_ASSERT_SVH

// Checked at every edge, reset included.
`define PDC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

// Checked only while out of reset.
`define PDC_ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`endif

FILE: sv/pdc_pkg.sv
// Shared types, codes and helper functions of the pill dispense controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pdc_pkg;

    // Input beat: one tick or a start request
    typedef struct packed {
        logic       kind;
        logic       beam_level;
        logic [7:0] pill_request;
    } t_in_item;

    // Result beat
    typedef struct packed {
        logic [3:0]  coils;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  status;
        logic [7:0]  pill_count;
        logic [31:0] total_pills;
        logic        break_closed;
        logic [15:0] break_ms;
        logic        break_counted;
    } t_out_item;

    // Configuration register set
    typedef struct packed {
        logic        idle_level;
        logic [7:0]  min_break_ms;
        logic [15:0] jam_ms;
        logic [15:0] base_timeout_ms;
        logic [15:0] per_pill_timeout_ms;
        logic [7:0]  step_period_ms;
        logic [15:0] settle_ms;
        logic        dispense_forward;
    } t_cfg;

    // Beam tracker view, values after the current beat
    typedef struct packed {
        logic        broken;
        logic [15:0] elapsed;
        logic [7:0]  pill_count;
        logic [31:0] total;
        logic        closed;
        logic [15:0] break_ms;
        logic        counted;
    } t_beam_info;

    // Run sequencer view, values after the current beat
    typedef struct packed {
        logic [3:0] coils;
        logic       busy;
        logic       done;
        logic [1:0] status;
    } t_run_info;

    // Stepper position and countdown
    typedef struct packed {
        logic [2:0] idx;
        logic [7:0] cnt;
    } t_step;

    // Run phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_DISP   = 3'b010,
        PH_SETTLE = 3'b100
    } t_phase;

    // Item kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    // Completion status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_JAM   = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LEVEL   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BREAK    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_JAM          = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_TIMEOUT = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PILL_TIMEOUT = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE       = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DISP_FWD     = 4'd7;
    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic        RST_IDLE_LEVEL   = 1'b1;
    localparam logic [7:0]  RST_MIN_BREAK    = 8'd8;
    localparam logic [15:0] RST_JAM          = 16'd1500;
    localparam logic [15:0] RST_BASE_TIMEOUT = 16'd5000;
    localparam logic [15:0] RST_PILL_TIMEOUT = 16'd15000;
    localparam logic [7:0]  RST_STEP_PERIOD  = 8'd2;
    localparam logic [15:0] RST_SETTLE       = 16'd1000;
    localparam logic        RST_DISP_FWD     = 1'b1;

    // Saturation limits
    localparam logic [7:0]  PILL_MAX  = 8'hFF;
    localparam logic [15:0] BREAK_MAX = 16'hFFFF;
    localparam logic [23:0] RUN_MAX   = 24'hFF_FFFF;

    // Half-step coil pattern, bit0 drives the first coil
    function automatic logic [3:0] halfstep(input logic [2:0] idx);
        logic [3:0] pat;
        case (idx)
            3'd0:    pat = 4'b0001;
            3'd1:    pat = 4'b0011;
            3'd2:    pat = 4'b0010;
            3'd3:    pat = 4'b0110;
            3'd4:    pat = 4'b0100;
            3'd5:    pat = 4'b1100;
            3'd6:    pat = 4'b1000;
            3'd7:    pat = 4'b1001;
            default: pat = 4'b0000;
        endcase
        return pat;
    endfunction

    // One tick of the step timer: step on zero and reload, else count down
    function automatic t_step timed_step(input logic [7:0] cnt, input logic [2:0] idx,
                                         input logic fwd, input logic [7:0] period);
        t_step res;
        res.idx = idx;
        res.cnt = cnt - 8'd1;
        if (cnt == 8'd0) begin
            res.idx = fwd ? (idx + 3'd1) : (idx - 3'd1);
            // a zero period behaves as one
            res.cnt = (period == 8'd0) ? 8'd0 : (period - 8'd1);
        end
        return res;
    endfunction

endpackage

FILE: sv/pdc_cfg.sv
// Configuration register file of the dispense controller.
// Depends on pdc_pkg for the register set type, indexes and reset values.
`timescale 1ns / 1ps

module pdc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pdc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pdc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output pdc_pkg::t_cfg                  o_cfg
);
    import pdc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic wr_en;

    // Writes are taken in any cycle
    assign o_cfg_ready = 1'b1;
    assign wr_en       = i_cfg_valid && o_cfg_ready;

    // Decode the index into one register field
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (i_cfg_index)
                CFG_IDLE_LEVEL:   n_cfg.idle_level          = i_cfg_data[0];
                CFG_MIN_BREAK:    n_cfg.min_break_ms        = i_cfg_data[7:0];
                CFG_JAM:          n_cfg.jam_ms              = i_cfg_data;
                CFG_BASE_TIMEOUT: n_cfg.base_timeout_ms     = i_cfg_data;
                CFG_PILL_TIMEOUT: n_cfg.per_pill_timeout_ms = i_cfg_data;
                CFG_STEP_PERIOD:  n_cfg.step_period_ms      = i_cfg_data[7:0];
                CFG_SETTLE:       n_cfg.settle_ms           = i_cfg_data;
                CFG_DISP_FWD:     n_cfg.dispense_forward    = i_cfg_data[0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_level          <= RST_IDLE_LEVEL;
            r_cfg.min_break_ms        <= RST_MIN_BREAK;
            r_cfg.jam_ms              <= RST_JAM;
            r_cfg.base_timeout_ms     <= RST_BASE_TIMEOUT;
            r_cfg.per_pill_timeout_ms <= RST_PILL_TIMEOUT;
            r_cfg.step_period_ms      <= RST_STEP_PERIOD;
            r_cfg.settle_ms           <= RST_SETTLE;
            r_cfg.dispense_forward    <= RST_DISP_FWD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: sv/pdc_beam.sv
// Beam break tracker: edge detection, break length and pill counters.
// Depends on pdc_pkg for the configuration and tracker view types.
`timescale 1ns / 1ps

module pdc_beam (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tick,
    input  logic                i_clear,
    input  logic                i_level,
    input  pdc_pkg::t_cfg       i_cfg,
    output pdc_pkg::t_beam_info o_beam
);
    import pdc_pkg::*;

    logic        r_prev,    n_prev;
    logic        r_broken,  n_broken;
    logic [15:0] r_elapsed, n_elapsed;
    logic [7:0]  r_pill,    n_pill;
    logic [31:0] r_total,   n_total;
    logic        closed;
    logic [15:0] bms;
    logic        counted;

    // Per-tick update: grow the open break, then handle the level change
    always_comb begin
        n_broken  = r_broken;
        n_elapsed = r_elapsed;
        n_pill    = r_pill;
        n_total   = r_total;
        n_prev    = r_prev;
        closed    = 1'b0;
        bms       = '0;
        counted   = 1'b0;
        if (i_clear) begin
            // start of a run: drop any open break, keep the last level
            n_broken  = 1'b0;
            n_elapsed = '0;
            n_pill    = '0;
        end else if (i_tick) begin
            n_prev = i_level;
            if (r_broken && (r_elapsed != BREAK_MAX)) begin
                n_elapsed = r_elapsed + 16'd1;
            end
            if (i_level != r_prev) begin
                if (i_level != i_cfg.idle_level) begin
                    if (!r_broken) begin
                        n_broken  = 1'b1;
                        n_elapsed = '0;
                    end
                end else if (r_broken) begin
                    n_broken = 1'b0;
                    closed   = 1'b1;
                    bms      = n_elapsed;
                    counted  = (n_elapsed >= 16'(i_cfg.min_break_ms));
                    if (counted) begin
                        if (r_pill != PILL_MAX) begin
                            n_pill = r_pill + 8'd1;
                        end
                        n_total = r_total + 32'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= RST_IDLE_LEVEL;
            r_broken  <= 1'b0;
            r_elapsed <= '0;
            r_pill    <= '0;
            r_total   <= '0;
        end else begin
            r_prev    <= n_prev;
            r_broken  <= n_broken;
            r_elapsed <= n_elapsed;
            r_pill    <= n_pill;
            r_total   <= n_total;
        end
    end

    assign o_beam.broken     = n_broken;
    assign o_beam.elapsed    = n_elapsed;
    assign o_beam.pill_count = n_pill;
    assign o_beam.total      = n_total;
    assign o_beam.closed     = closed;
    assign o_beam.break_ms   = bms;
    assign o_beam.counted    = counted;

endmodule

FILE: sv/pdc_run.sv
// Run sequencer: dispense and settle phases, stepper timing, end of run.
// Depends on pdc_pkg for phase codes, status codes and step helpers.
`timescale 1ns / 1ps

module pdc_run (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tick,
    input  logic                i_start,
    input  logic [7:0]          i_req,
    input  pdc_pkg::t_cfg       i_cfg,
    input  pdc_pkg::t_beam_info i_beam,
    output logic                o_idle,
    output pdc_pkg::t_run_info  o_run
);
    import pdc_pkg::*;

    t_phase      r_phase,   n_phase;
    logic [2:0]  r_idx,     n_idx;
    logic [7:0]  r_cnt,     n_cnt;
    logic [23:0] r_elapsed, n_elapsed;
    logic [23:0] r_limit,   n_limit;
    logic [7:0]  r_req,     n_req;
    logic        done;
    logic [1:0]  status;
    logic        settle_now;
    logic [23:0] s_el;
    logic [7:0]  s_cnt;
    logic [23:0] el1;
    logic [7:0]  req_eff;
    logic [23:0] limit_new;
    t_step       stp;

    assign o_idle  = (r_phase == PH_IDLE);
    assign req_eff = (i_req == 8'd0) ? 8'd1 : i_req;
    // 16 x 8 product plus base always fits 24 bits
    assign limit_new = 24'(i_cfg.base_timeout_ms)
                     + 24'(i_cfg.per_pill_timeout_ms) * 24'(req_eff);
    assign el1 = (r_elapsed != RUN_MAX) ? (r_elapsed + 24'd1) : r_elapsed;

    // Phase sequencing for one beat
    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_cnt      = r_cnt;
        n_elapsed  = r_elapsed;
        n_limit    = r_limit;
        n_req      = r_req;
        done       = 1'b0;
        status     = ST_OK;
        settle_now = 1'b0;
        s_el       = r_elapsed;
        s_cnt      = r_cnt;
        stp        = '0;
        if (i_start) begin
            // a start while busy is ignored
            if (r_phase == PH_IDLE) begin
                n_req     = req_eff;
                n_elapsed = '0;
                n_limit   = limit_new;
                n_cnt     = '0;
                n_phase   = PH_DISP;
            end
        end else if (i_tick) begin
            case (r_phase)
                PH_DISP: begin
                    n_elapsed = el1;
                    if (i_beam.pill_count >= r_req) begin
                        // enough pills: settle starts on this same tick
                        settle_now = 1'b1;
                        s_el       = '0;
                        s_cnt      = '0;
                    end else if (i_beam.broken && (i_beam.elapsed > i_cfg.jam_ms)) begin
                        done    = 1'b1;
                        status  = ST_JAM;
                        n_phase = PH_IDLE;
                    end else if (el1 > r_limit) begin
                        done    = 1'b1;
                        status  = (i_beam.pill_count != 8'd0) ? ST_SHORT : ST_JAM;
                        n_phase = PH_IDLE;
                    end else begin
                        stp   = timed_step(r_cnt, r_idx, i_cfg.dispense_forward,
                                           i_cfg.step_period_ms);
                        n_idx = stp.idx;
                        n_cnt = stp.cnt;
                    end
                end
                PH_SETTLE: begin
                    settle_now = 1'b1;
                end
                PH_IDLE: begin
                    n_phase = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase

            // settle: reverse stepping until settle_ms ticks have passed
            if (settle_now) begin
                n_phase   = PH_SETTLE;
                n_elapsed = s_el;
                n_cnt     = s_cnt;
                if (s_el >= 24'(i_cfg.settle_ms)) begin
                    done    = 1'b1;
                    status  = ST_OK;
                    n_phase = PH_IDLE;
                end else begin
                    n_elapsed = s_el + 24'd1;
                    stp       = timed_step(s_cnt, r_idx, !i_cfg.dispense_forward,
                                           i_cfg.step_period_ms);
                    n_idx     = stp.idx;
                    n_cnt     = stp.cnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_idx     <= '0;
            r_cnt     <= '0;
            r_elapsed <= '0;
            r_limit   <= '0;
            r_req     <= '0;
        end else begin
            r_phase   <= n_phase;
            r_idx     <= n_idx;
            r_cnt     <= n_cnt;
            r_elapsed <= n_elapsed;
            r_limit   <= n_limit;
            r_req     <= n_req;
        end
    end

    assign o_run.busy   = (n_phase != PH_IDLE);
    assign o_run.coils  = (n_phase != PH_IDLE) ? halfstep(n_idx) : 4'b0000;
    assign o_run.done   = done;
    assign o_run.status = done ? status : ST_OK;

endmodule

FILE: sv/pill_dispense_controller_core.sv
// Top level of the pill dispense controller: input register, update logic, result register.
// Depends on pdc_pkg, pdc_cfg, pdc_beam and pdc_run.
//
//   channel   signals                                   direction
//   input     i_in_valid, o_in_stall, i_in_data         tick or start beat in
//   result    o_out_valid, i_out_stall, o_out_data      one result beat per input beat
//   config    i_cfg_valid, o_cfg_ready, i_cfg_index,    register write
//             i_cfg_data
//
// An input beat is registered, then processed into the result register;
// one beat per cycle is sustained while the result side does not stall.
// The update of beam tracker and run sequencer is combinational logic.
// Synchronous active-low reset clears all control and counter state.
// A stalled result holds; the input side stalls only while its register cannot drain.
`timescale 1ns / 1ps

module pill_dispense_controller_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  pdc_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output pdc_pkg::t_out_item             o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pdc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pdc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pdc_pkg::*;

    logic       r_in_valid;
    t_in_item   r_in_data;
    logic       r_out_valid;
    t_out_item  r_out_data;
    t_out_item  n_out_data;
    logic       advance;
    logic       accept_in;
    logic       tick;
    logic       start;
    logic       run_idle;
    t_cfg       cfg;
    t_beam_info beam;
    t_run_info  run;

    // Handshake: process the held beat whenever the result register is free
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign accept_in  = i_in_valid && !o_in_stall;
    assign tick       = advance && (r_in_data.kind == KIND_TICK);
    assign start      = advance && (r_in_data.kind == KIND_START);

    pdc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pdc_beam u_beam (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick),
        .i_clear (start && run_idle),
        .i_level (r_in_data.beam_level),
        .i_cfg   (cfg),
        .o_beam  (beam)
    );

    pdc_run u_run (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick),
        .i_start (start),
        .i_req   (r_in_data.pill_request),
        .i_cfg   (cfg),
        .i_beam  (beam),
        .o_idle  (run_idle),
        .o_run   (run)
    );

    // Result beat assembly
    always_comb begin
        n_out_data.coils         = run.coils;
        n_out_data.busy_res      = run.busy;
        n_out_data.done_res      = run.done;
        n_out_data.status        = run.status;
        n_out_data.pill_count    = beam.pill_count;
        n_out_data.total_pills   = beam.total;
        n_out_data.break_closed  = beam.closed;
        n_out_data.break_ms      = beam.break_ms;
        n_out_data.break_counted = beam.counted;
    end

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= accept_in || (r_in_valid && !advance);
            r_out_valid <= advance || (r_out_valid && i_out_stall);
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_in_data <= i_in_data;
        end
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: sv/pdc_port_checker.sv
// Port-level checker for the dispense controller, bound to the top level.
// Depends on pdc_pkg and the assertion macro header.
`timescale 1ns / 1ps

`include "pill_dispense_controller_core_assert.svh"

module pdc_port_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input pdc_pkg::t_out_item o_out_data
);
    import pdc_pkg::*;

    // Result-side views used by the checks
    logic empty;
    logic held;
    logic fin;
    logic quiet;
    logic mid;
    logic counted;

    assign empty   = !o_out_valid && !o_in_stall;
    assign held    = o_out_valid && i_out_stall;
    assign fin     = o_out_valid && o_out_data.done_res;
    assign quiet   = !o_out_data.busy_res && (o_out_data.coils == 4'b0000);
    assign mid     = o_out_valid && !o_out_data.done_res;
    assign counted = o_out_valid && o_out_data.break_counted;

    // Reset empties both sides
    `PDC_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> empty, "not empty after reset")

    // A stalled result beat holds
    `PDC_ASSERT_RUN(a_out_hold, held |=> (o_out_valid && $stable(o_out_data)), "held beat changed")

    // The beat ending a run drives no coils and shows idle
    `PDC_ASSERT_RUN(a_done_idle, fin |-> quiet, "done while busy")

    // Status is only reported with done
    `PDC_ASSERT_RUN(a_status_done, mid |-> (o_out_data.status == ST_OK), "status without done")

    // Only a closed break can be counted
    `PDC_ASSERT_RUN(a_count_closed, counted |-> o_out_data.break_closed, "count without close")

endmodule

bind pill_dispense_controller_core pdc_port_checker u_pdc_port_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

FILE: dv/pill_dispense_controller_core_tb.sv
// Self-checking testbench for pill_dispense_controller_core: directed and random tick/start
// beats, an in-bench predictor of the dispenser, and a field-by-field result check.
// Depends on pdc_pkg and the controller RTL.
`timescale 1ns / 1ps

module pill_dispense_controller_core_tb;
    import pdc_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    // half-step coil table, entry i in bits [4i+3:4i]
    localparam logic [31:0] COIL_SEQ = 32'h98C4_6231;

    // clock, reset and channel signals
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    t_in_item in_data = '0;
    logic in_stall;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out_item out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor copy of the registers and the dispenser state
    t_cfg cur_cfg;
    logic last_level;
    logic in_break;
    logic [15:0] break_len;
    logic [7:0] pills_since_start;
    logic [31:0] pills_total;
    t_phase run_phase;
    logic [2:0] step_pos;
    logic [7:0] step_wait;
    logic [23:0] run_ticks;
    logic [23:0] run_limit;
    logic [7:0] pills_wanted;
    logic [1:0] end_status;

    // expected result beats, oldest first
    t_out_item dispense_reports[$];

    // bookkeeping
    logic idle_on = 1'b1;
    int stall_left = 0;
    int cycle_count = 0;
    int beats_sent = 0;
    int results_seen = 0;
    int mismatches = 0;
    int runs_ok = 0;
    int runs_short = 0;
    int runs_jam = 0;

    pill_dispense_controller_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void clear_model();
        cur_cfg.idle_level          = RST_IDLE_LEVEL;
        cur_cfg.min_break_ms        = RST_MIN_BREAK;
        cur_cfg.jam_ms              = RST_JAM;
        cur_cfg.base_timeout_ms     = RST_BASE_TIMEOUT;
        cur_cfg.per_pill_timeout_ms = RST_PILL_TIMEOUT;
        cur_cfg.step_period_ms      = RST_STEP_PERIOD;
        cur_cfg.settle_ms           = RST_SETTLE;
        cur_cfg.dispense_forward    = RST_DISP_FWD;
        last_level        = RST_IDLE_LEVEL;
        in_break          = 1'b0;
        break_len         = '0;
        pills_since_start = '0;
        pills_total       = '0;
        run_phase         = PH_IDLE;
        step_pos          = '0;
        step_wait         = '0;
        run_ticks         = '0;
        run_limit         = '0;
        pills_wanted      = '0;
        end_status        = ST_OK;
    endfunction

    // one step timer tick in the given direction
    function automatic void step_motor(input logic fwd);
        if (step_wait == 8'd0) begin
            step_pos  = fwd ? step_pos + 3'd1 : step_pos - 3'd1;
            step_wait = (cur_cfg.step_period_ms == 8'd0) ? 8'd0 : cur_cfg.step_period_ms - 8'd1;
        end else begin
            step_wait = step_wait - 8'd1;
        end
    endfunction

    // advance the dispenser by one accepted beat and return its result
    function automatic t_out_item predict_report(input t_in_item it);
        t_out_item r;
        logic fwd;
        logic done;
        r    = '0;
        done = 1'b0;
        fwd  = cur_cfg.dispense_forward;
        if (it.kind == KIND_START) begin
            // a start while busy is ignored
            if (run_phase == PH_IDLE) begin
                pills_wanted      = (it.pill_request == 8'd0) ? 8'd1 : it.pill_request;
                pills_since_start = '0;
                in_break          = 1'b0;
                break_len         = '0;
                run_ticks         = '0;
                run_limit         = 24'(cur_cfg.base_timeout_ms)
                                  + 24'(cur_cfg.per_pill_timeout_ms) * 24'(pills_wanted);
                step_wait         = '0;
                end_status        = ST_OK;
                run_phase         = PH_DISP;
            end
        end else begin
            // beam tracking runs in every phase
            if (in_break && break_len != BREAK_MAX) break_len = break_len + 16'd1;
            if (it.beam_level != last_level) begin
                if (it.beam_level != cur_cfg.idle_level) begin
                    if (!in_break) begin
                        in_break  = 1'b1;
                        break_len = '0;
                    end
                end else if (in_break) begin
                    in_break        = 1'b0;
                    r.break_closed  = 1'b1;
                    r.break_ms      = break_len;
                    r.break_counted = (break_len >= 16'(cur_cfg.min_break_ms));
                    if (r.break_counted) begin
                        if (pills_since_start != PILL_MAX)
                            pills_since_start = pills_since_start + 8'd1;
                        pills_total = pills_total + 32'd1;
                    end
                end
            end
            last_level = it.beam_level;

            // dispensing: count, jam, timeout, else step
            if (run_phase == PH_DISP) begin
                if (run_ticks != RUN_MAX) run_ticks = run_ticks + 24'd1;
                if (pills_since_start >= pills_wanted) begin
                    run_phase = PH_SETTLE;
                    run_ticks = '0;
                    step_wait = '0;
                end else if (in_break && break_len > cur_cfg.jam_ms) begin
                    end_status = ST_JAM;
                    done       = 1'b1;
                    run_phase  = PH_IDLE;
                end else if (run_ticks > run_limit) begin
                    end_status = (pills_since_start != 8'd0) ? ST_SHORT : ST_JAM;
                    done       = 1'b1;
                    run_phase  = PH_IDLE;
                end else begin
                    step_motor(fwd);
                end
            end
            // settling steps the other way, may start on the same tick
            if (run_phase == PH_SETTLE) begin
                if (run_ticks >= 24'(cur_cfg.settle_ms)) begin
                    end_status = ST_OK;
                    done       = 1'b1;
                    run_phase  = PH_IDLE;
                end else begin
                    run_ticks = run_ticks + 24'd1;
                    step_motor(!fwd);
                end
            end
        end
        r.coils       = (run_phase == PH_IDLE) ? 4'd0 : COIL_SEQ[step_pos * 4 +: 4];
        r.busy_res    = (run_phase != PH_IDLE);
        r.done_res    = done;
        r.status      = done ? end_status : ST_OK;
        r.pill_count  = pills_since_start;
        r.total_pills = pills_total;
        return r;
    endfunction

    // ---------------------------------------------------------------- result side

    task automatic note_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatches < 50)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                     $time, field, got, want);
        mismatches++;
    endtask

    // random stall bursts of random length while idle insertion is on
    always @(posedge clk) begin
        if (!rst_n || !idle_on) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left != 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else if ($urandom_range(0, 5) == 0) begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(0, 6);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // compare each accepted result beat with the oldest expectation
    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (dispense_reports.size() == 0) begin
                note_mismatch("unexpected result beat", out_data.total_pills, 32'd0);
            end else begin
                want = dispense_reports.pop_front();
                if (out_data.coils !== want.coils)
                    note_mismatch("coils", out_data.coils, want.coils);
                if (out_data.busy_res !== want.busy_res)
                    note_mismatch("busy_res", out_data.busy_res, want.busy_res);
                if (out_data.done_res !== want.done_res)
                    note_mismatch("done_res", out_data.done_res, want.done_res);
                if (out_data.status !== want.status)
                    note_mismatch("status", out_data.status, want.status);
                if (out_data.pill_count !== want.pill_count)
                    note_mismatch("pill_count", out_data.pill_count, want.pill_count);
                if (out_data.total_pills !== want.total_pills)
                    note_mismatch("total_pills", out_data.total_pills, want.total_pills);
                if (out_data.break_closed !== want.break_closed)
                    note_mismatch("break_closed", out_data.break_closed, want.break_closed);
                if (out_data.break_ms !== want.break_ms)
                    note_mismatch("break_ms", out_data.break_ms, want.break_ms);
                if (out_data.break_counted !== want.break_counted)
                    note_mismatch("break_counted", out_data.break_counted, want.break_counted);
                if (want.done_res) begin
                    case (want.status)
                        ST_OK:    runs_ok++;
                        ST_SHORT: runs_short++;
                        default:  runs_jam++;
                    endcase
                end
            end
        end
    end

    // ---------------------------------------------------------------- input side

    // send one beat, with an optional idle burst ahead of it
    task automatic send_beat(input t_in_item it);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        dispense_reports.push_back(predict_report(it));
        beats_sent++;
    endtask

    task automatic send_tick(input logic level);
        t_in_item it;
        it.kind         = KIND_TICK;
        it.beam_level   = level;
        it.pill_request = 8'($urandom);
        send_beat(it);
    endtask

    task automatic send_start(input logic [7:0] count);
        t_in_item it;
        it.kind         = KIND_START;
        it.beam_level   = 1'($urandom_range(0, 1));
        it.pill_request = count;
        send_beat(it);
    endtask

    // beam broken for len ticks, then clear for gap ticks
    task automatic send_pulse(input int len, input int gap);
        repeat (len) send_tick(!cur_cfg.idle_level);
        repeat (gap) send_tick(cur_cfg.idle_level);
    endtask

    // drop valid, wait for every result, then let the pipeline settle
    task automatic wait_quiet();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (dispense_reports.size() != 0 && waited < 5000) begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    // tick until the run is over: either let it expire or feed it pills
    task automatic finish_run();
        int guard;
        int held;
        logic expire;
        guard  = 0;
        held   = 0;
        expire = ($urandom_range(0, 1) == 1) && (run_limit < 24'd2000);
        while (run_phase != PH_IDLE && guard < 20000) begin
            if (expire || held > int'(cur_cfg.min_break_ms)) begin
                send_tick(cur_cfg.idle_level);
                held = 0;
            end else begin
                send_tick(!cur_cfg.idle_level);
                held++;
            end
            guard++;
        end
    endtask

    // ---------------------------------------------------------------- registers

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] wdata);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= wdata;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic apply_settings(input t_cfg c);
        write_reg(CFG_IDLE_LEVEL,   16'(c.idle_level));
        write_reg(CFG_MIN_BREAK,    16'(c.min_break_ms));
        write_reg(CFG_JAM,          c.jam_ms);
        write_reg(CFG_BASE_TIMEOUT, c.base_timeout_ms);
        write_reg(CFG_PILL_TIMEOUT, c.per_pill_timeout_ms);
        write_reg(CFG_STEP_PERIOD,  16'(c.step_period_ms));
        write_reg(CFG_SETTLE,       c.settle_ms);
        write_reg(CFG_DISP_FWD,     16'(c.dispense_forward));
        cfg_valid <= 1'b0;
        cur_cfg = c;
    endtask

    function automatic t_cfg cfg_of(input logic idle, input int minb, input int jam,
                                    input int base, input int per, input int step,
                                    input int settle, input logic fwd);
        t_cfg c;
        c.idle_level          = idle;
        c.min_break_ms        = 8'(minb);
        c.jam_ms              = 16'(jam);
        c.base_timeout_ms     = 16'(base);
        c.per_pill_timeout_ms = 16'(per);
        c.step_period_ms      = 8'(step);
        c.settle_ms           = 16'(settle);
        c.dispense_forward    = fwd;
        return c;
    endfunction

    // short runs with every end reachable
    function automatic t_cfg tight_set();
        return cfg_of(1'b1, 2, 12, 6, 4, 1, 6, 1'b1);
    endfunction

    // all registers at their low end
    function automatic t_cfg zero_set();
        return cfg_of(1'b0, 0, 0, 0, 0, 0, 0, 1'b0);
    endfunction

    // ---------------------------------------------------------------- random helpers

    function automatic logic [7:0] pick_request(input int cap);
        return ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, cap));
    endfunction

    // break lengths: short, near the pill threshold, or just past the jam limit
    function automatic int pulse_length();
        int minb;
        int jam;
        minb = int'(cur_cfg.min_break_ms);
        jam  = int'(cur_cfg.jam_ms);
        case ($urandom_range(0, 7))
            0:       return (jam < 300) ? jam + $urandom_range(1, 3) : $urandom_range(1, 4);
            1, 2, 3: return $urandom_range(1, 8);
            default: return $urandom_range((minb > 2) ? minb - 2 : 1, minb + 2);
        endcase
    endfunction

    // ---------------------------------------------------------------- tests

    // pill threshold at the reset settings, no run
    task automatic test_idle_breaks();
        send_tick(1'b1);
        send_tick(1'b1);
        send_pulse(7, 2);
        send_pulse(8, 2);
        send_tick(1'b1);
        wait_quiet();
    endtask

    // a run that counts its pill, ignores a second start and settles back
    task automatic test_dispense_ok();
        apply_settings(tight_set());
        send_start(8'd0);
        send_tick(1'b1);
        send_start(8'hAA);
        send_pulse(3, 1);
        repeat (8) send_tick(1'b1);
        wait_quiet();
    endtask

    // jam on a long break, timeout with nothing counted, timeout short
    task automatic test_run_faults();
        apply_settings(tight_set());
        send_start(8'd2);
        send_pulse(14, 1);
        send_start(8'd1);
        repeat (12) send_tick(1'b1);
        send_start(8'd2);
        send_pulse(3, 1);
        repeat (16) send_tick(1'b1);
        wait_quiet();
    endtask

    // start with the beam already broken, then a clear edge with no break open
    task automatic test_start_while_broken();
        apply_settings(tight_set());
        send_tick(1'b0);
        send_tick(1'b0);
        send_start(8'd1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_pulse(2, 1);
        repeat (8) send_tick(1'b1);
        wait_quiet();
    endtask

    // low extremes: zero timeout, zero jam, zero period, largest request
    task automatic test_zero_settings();
        apply_settings(zero_set());
        send_pulse(1, 1);
        send_start(8'd255);
        send_tick(1'b0);
        send_tick(1'b1);
        send_start(8'd0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_pulse(2, 1);
        wait_quiet();
    endtask

    // enough short breaks in idle to pin the pill count at its maximum
    task automatic test_count_saturation();
        apply_settings(zero_set());
        repeat (262) send_pulse($urandom_range(1, 2), 1);
        wait_quiet();
    endtask

    // random runs, noise and quiet stretches under one register setting
    task automatic test_random(input t_cfg c, input int beats, input int req_cap,
                               input logic with_idle);
        int stop_at;
        int pick;
        apply_settings(c);
        idle_on = with_idle;
        stop_at = beats_sent + beats;
        while (beats_sent < stop_at) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                // well-formed run with random breaks
                send_start(pick_request(req_cap));
                repeat ($urandom_range(1, 4)) begin
                    send_pulse(pulse_length(), $urandom_range(1, 6));
                    if (run_phase != PH_IDLE && $urandom_range(0, 5) == 0)
                        send_start(8'($urandom));
                end
                finish_run();
            end else if (pick < 9) begin
                // noise on the beam with the odd start
                repeat ($urandom_range(4, 20)) begin
                    if ($urandom_range(0, 9) == 0)
                        send_start((run_phase == PH_IDLE) ? pick_request(req_cap)
                                                          : 8'($urandom));
                    else
                        send_tick(1'($urandom_range(0, 1)));
                end
                finish_run();
            end else begin
                repeat ($urandom_range(1, 10)) send_tick(cur_cfg.idle_level);
            end
        end
        wait_quiet();
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        clear_model();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_idle_breaks();
        test_dispense_ok();
        test_run_faults();
        test_start_while_broken();
        test_zero_settings();
        test_count_saturation();
        test_random(tight_set(), 200, 6, 1'b1);
        test_random(zero_set(), 120, 255, 1'b1);
        test_random(cfg_of(1'b1, 255, 200, 40, 10, 255, 65535, 1'b1), 120, 255, 1'b1);
        test_random(cfg_of(1'b0, 3, 65535, 65535, 65535, 3, 4, 1'b1), 120, 3, 1'b1);
        test_random(cfg_of(1'b0, 1, 9, 12, 6, 0, 3, 1'b0), 180, 8, 1'b0);

        if (dispense_reports.size() != 0) begin
            $display("%0d expected result beats never arrived", dispense_reports.size());
            mismatches += dispense_reports.size();
        end
        $display("Sent %0d tick/start beats over six register settings, checked %0d results",
                 beats_sent, results_seen);
        $display("Runs ended: %0d ok, %0d short, %0d jam", runs_ok, runs_short, runs_jam);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
